FILE: rtl/alc_pkg.sv
package alc_pkg;

  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned LUX_W   = 25;
  localparam int unsigned OUT_W   = 27;
  localparam int unsigned P_W     = 80;
  localparam int unsigned ACC_W   = 108;
  localparam int unsigned CHUNK_W = 32;
  localparam int unsigned FRAC_W  = 56;
  localparam int unsigned ADDR_W  = 3;

  localparam logic [BASE_W-1:0] BASE_RES_Q_DEF = 16'd236;
  localparam logic [LUX_W-1:0]  CORR_LIMIT     = 25'd1000;

  // Horner coefficients, signed Q.56
  localparam logic [P_W-1:0]   COEF_A  = 80'd43332;
  localparam logic [ACC_W-1:0] COEF_B  = 108'd676793746;
  localparam logic [ACC_W-1:0] COEF_C  = 108'd5871829222963;
  localparam logic [ACC_W-1:0] COEF_D  = 108'd72223326504215170;

  // Register index (paddr bit 2)
  localparam logic REG_GAIN  = 1'b0;
  localparam logic REG_INTEG = 1'b1;

  // Horner pass codes
  localparam logic [1:0] PASS_P1  = 2'd0;
  localparam logic [1:0] PASS_P2  = 2'd1;
  localparam logic [1:0] PASS_P3  = 2'd2;
  localparam logic [1:0] PASS_FIN = 2'd3;

  localparam logic [1:0] GAIN_X1    = 2'd0;
  localparam logic [1:0] GAIN_X2    = 2'd1;
  localparam logic [1:0] GAIN_X1_8  = 2'd2;
  localparam logic [1:0] GAIN_X1_4  = 2'd3;
  localparam logic [2:0] INTEG_800  = 3'd5;

  typedef struct packed {
    logic [1:0] gain_sel;
    logic [2:0] integ_sel;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [P_W-1:0]   op_a;
    logic [LUX_W-1:0] op_b;
    logic [ACC_W-1:0] addend;
  } mac_cmd_t;

  // Total left shift of the resolution: integration plus gain
  function automatic logic [3:0] scale_shift(input cfg_t c);
    logic [2:0] isel;
    logic [3:0] gsh;
    isel = (c.integ_sel > INTEG_800) ? INTEG_800 : c.integ_sel;
    case (c.gain_sel)
      GAIN_X1:   gsh = 4'd1;
      GAIN_X2:   gsh = 4'd0;
      GAIN_X1_8: gsh = 4'd4;
      GAIN_X1_4: gsh = 4'd3;
      default:   gsh = 4'd0;
    endcase
    return {1'b0, INTEG_800 - isel} + gsh;
  endfunction

  function automatic logic [ACC_W-1:0] horner_addend(input logic [1:0] pass);
    logic [ACC_W-1:0] v;
    case (pass)
      PASS_P1: v = ~COEF_B + 108'd1;
      PASS_P2: v = COEF_C;
      PASS_P3: v = COEF_D;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Clamp to the signed 80-bit range
  function automatic logic [P_W-1:0] sat80(input logic [ACC_W-1:0] acc);
    logic [ACC_W-P_W:0] top;
    logic [P_W-1:0]     v;
    top = acc[ACC_W-1:P_W-1];
    if ((&top) || !(|top)) begin
      v = acc[P_W-1:0];
    end else if (acc[ACC_W-1]) begin
      v = {1'b1, {(P_W-1){1'b0}}};
    end else begin
      v = {1'b0, {(P_W-1){1'b1}}};
    end
    return v;
  endfunction

  // Drop the fraction, clamp negative to zero and large to all ones
  function automatic logic [OUT_W-1:0] final_lux(input logic [ACC_W-1:0] acc);
    logic [OUT_W-1:0] v;
    if (acc[ACC_W-1]) begin
      v = '0;
    end else if (|acc[ACC_W-1:FRAC_W+OUT_W]) begin
      v = '1;
    end else begin
      v = acc[FRAC_W+OUT_W-1:FRAC_W];
    end
    return v;
  endfunction

endpackage

FILE: rtl/alc_regs.sv
module alc_regs
  import alc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_sel  <= 2'd0;
      cfg_r.integ_sel <= 3'd2;
    end else if (wr_en) begin
      case (cfg_paddr[2])
        REG_GAIN:  cfg_r.gain_sel  <= cfg_pwdata[1:0];
        REG_INTEG: cfg_r.integ_sel <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_GAIN:  cfg_prdata = {30'd0, cfg_r.gain_sel};
      REG_INTEG: cfg_prdata = {29'd0, cfg_r.integ_sel};
      default:   cfg_prdata = '0;
    endcase
  end

endmodule

FILE: rtl/alc_mac.sv
module alc_mac
  import alc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  mac_cmd_t         cmd,
  output logic [ACC_W-1:0] acc,
  output logic             done
);

  localparam int unsigned PROD_W = CHUNK_W + 1 + LUX_W + 1;

  logic [P_W-1:0]           a_r;
  logic [LUX_W-1:0]         b_r;
  logic [ACC_W-1:0]         acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic [1:0]               cnt_r;
  logic                     busy_r;
  logic [CHUNK_W:0]         chunk;
  logic [ACC_W-1:0]         ext;
  logic [ACC_W-1:0]         term;

  // Pick one slice of the operand (32, 32 and 16 bits); the top slice carries the sign
  always_comb begin
    case (cnt_r)
      2'd0:    chunk = {1'b0, a_r[CHUNK_W-1:0]};
      2'd1:    chunk = {1'b0, a_r[2*CHUNK_W-1:CHUNK_W]};
      default: chunk = {{(3*CHUNK_W+1-P_W){a_r[P_W-1]}}, a_r[P_W-1:2*CHUNK_W]};
    endcase
  end

  assign prod_nxt = $signed(chunk) * $signed({1'b0, b_r});
  assign ext      = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // Align the product from the previous slice
  always_comb begin
    case (cnt_r)
      2'd1:    term = ext;
      2'd2:    term = ext << CHUNK_W;
      2'd3:    term = ext << (2 * CHUNK_W);
      default: term = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_r   <= cmd.op_a;
      b_r   <= cmd.op_b;
      acc_r <= cmd.addend;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      acc_r  <= acc_r + term;
    end
  end

  assign acc  = acc_r;
  assign done = busy_r && (cnt_r == 2'd3);

endmodule

FILE: rtl/ambient_light_lux_converter_top.sv
// Channel | Direction | Handshake              | Contents
// in_     | input     | in_tvalid / in_tready  | tuser: action, tdata: raw_count
// out_    | output    | out_tvalid / out_tready| tdata: ambient_lux, white_lux
// cfg_    | input     | APB, pready tied high  | gain_sel at 0x0, integ_sel at 0x4
//
// Flow: one item at a time. The quartic correction runs only when the scaled
// lux is above 1000; each Horner pass of the shared 33x26 multiply-accumulate
// unit is followed by a step that saturates the sum and issues the next pass
// or ends the correction (one scaling pass, four Horner passes).
// Reset: synchronous, active low; clears the sequencer, the stored lux values,
// the output valid and the registers (gain_sel 0, integ_sel 2).
// Stalls: the result waits in the output register; a new item is taken as soon
// as the sequencer is back in idle, even while that result is still pending.
module ambient_light_lux_converter_top
  import alc_pkg::*;
#(
  parameter logic [BASE_W-1:0] BASE_RES_Q = BASE_RES_Q_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,   // [15:0] raw_count
  input  logic              in_tuser,   // [0] action (0 ambient, 1 white)
  // result channel
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [55:0]       out_tdata,  // [26:0] ambient_lux, [53:27] white_lux, [55:54] zero
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_LUX   = 3'd2;
  localparam logic [2:0] S_HORN  = 3'd3;
  localparam logic [2:0] S_SAT   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  localparam int unsigned SCALED_W = 2 * BASE_W + 9;

  cfg_t             cfg;
  mac_cmd_t         cmd;
  logic [ACC_W-1:0] acc;
  logic             mac_done;

  logic [2:0]       state_r, state_nxt;
  logic [1:0]       pass_r;
  logic             action_r;
  logic [LUX_W-1:0] lux_r;
  logic [OUT_W-1:0] result_r;
  logic [OUT_W-1:0] amb_r, wht_r;
  logic [OUT_W-1:0] amb_nxt, wht_nxt;
  logic             out_valid_r;
  logic [55:0]      out_data_r;

  logic [SCALED_W-1:0] scaled;
  logic [LUX_W-1:0]    lux_comb;
  logic                in_acc;
  logic                out_go;

  alc_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  alc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc),
    .done  (mac_done)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_go    = (state_r == S_OUT) && (!out_valid_r || out_tready);

  // count * BASE_RES_Q sits in the low bits of the accumulator; shift by the
  // setting and drop the 16 fraction bits
  assign scaled   = {{(SCALED_W-2*BASE_W){1'b0}}, acc[2*BASE_W-1:0]} << scale_shift(cfg);
  assign lux_comb = scaled[SCALED_W-1:BASE_W];

  // Replace the stored value of the selected channel
  assign amb_nxt = action_r ? amb_r : result_r;
  assign wht_nxt = action_r ? result_r : wht_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.start  = 1'b0;
    cmd.op_a   = sat80(acc);
    cmd.op_b   = lux_r;
    cmd.addend = horner_addend(2'(pass_r + 2'd1));
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd.start  = 1'b1;
          cmd.op_a   = {{(P_W-COUNT_W){1'b0}}, in_tdata};
          cmd.op_b   = {{(LUX_W-BASE_W){1'b0}}, BASE_RES_Q};
          cmd.addend = '0;
          state_nxt  = S_SCALE;
        end
      end
      S_SCALE: begin
        if (mac_done) begin
          state_nxt = S_LUX;
        end
      end
      S_LUX: begin
        // Correct only above 1000 lux
        if (lux_comb > CORR_LIMIT) begin
          cmd.start  = 1'b1;
          cmd.op_a   = COEF_A;
          cmd.op_b   = lux_comb;
          cmd.addend = horner_addend(PASS_P1);
          state_nxt  = S_HORN;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_HORN: begin
        if (mac_done) begin
          state_nxt = S_SAT;
        end
      end
      S_SAT: begin
        if (pass_r == PASS_FIN) begin
          state_nxt = S_OUT;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_HORN;
        end
      end
      S_OUT: begin
        if (out_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pass_r      <= PASS_P1;
      amb_r       <= '0;
      wht_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LUX) begin
        pass_r <= PASS_P1;
      end else if ((state_r == S_SAT) && (pass_r != PASS_FIN)) begin
        pass_r <= pass_r + 2'd1;
      end
      if (out_go) begin
        amb_r       <= amb_nxt;
        wht_r       <= wht_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_r <= in_tuser;
    end
    if (state_r == S_LUX) begin
      lux_r    <= lux_comb;
      result_r <= {{(OUT_W-LUX_W){1'b0}}, lux_comb};
    end
    if ((state_r == S_SAT) && (pass_r == PASS_FIN)) begin
      result_r <= final_lux(acc);
    end
    if (out_go) begin
      out_data_r <= {2'b00, wht_nxt, amb_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: rtl/alc_chk.sv
module alc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // An accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // A new result only appears after the block was busy
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without work");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable(out_tdata))
    else $error("result changed while stalled");

endmodule

bind ambient_light_lux_converter_top alc_chk u_alc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/tb_top.sv
module tb_top;
  import alc_pkg::*;

  localparam logic [BASE_W-1:0] BASE_RES = BASE_RES_Q_DEF;

  // Channel select carried in tuser
  localparam logic CHAN_AMBIENT = 1'b0;
  localparam logic CHAN_WHITE   = 1'b1;

  // Register byte addresses (register index in paddr bit 2)
  localparam logic [ADDR_W-1:0] GAIN_ADDR  = {REG_GAIN, 2'b00};
  localparam logic [ADDR_W-1:0] INTEG_ADDR = {REG_INTEG, 2'b00};
  localparam logic [2:0]        INTEG_RST  = 3'd2;

  // Quartic correction coefficients, signed Q.56
  localparam logic signed [127:0] Q56_A = 128'sd43332;
  localparam logic signed [127:0] Q56_B = 128'sd676793746;
  localparam logic signed [127:0] Q56_C = 128'sd5871829222963;
  localparam logic signed [127:0] Q56_D = 128'sd72223326504215170;

  localparam int PHASES     = 12;
  localparam int PHASE_LEN  = 150;
  localparam int SETTLE_CYC = 40;

  typedef struct {
    logic [OUT_W-1:0] ambient;
    logic [OUT_W-1:0] white;
  } lux_pair_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  // Shadow of the block's registers and held lux values
  logic [1:0]        gain_now = GAIN_X1;
  logic [2:0]        integ_now = INTEG_RST;
  logic [OUT_W-1:0]  held_ambient = '0;
  logic [OUT_W-1:0]  held_white = '0;

  lux_pair_t         expected_lux_q[$];
  bit                no_idle = 1'b0;
  int                fail_count = 0;
  int                items_sent = 0;
  int                results_checked = 0;
  int                corrected_items = 0;
  int                reg_writes = 0;

  ambient_light_lux_converter_top #(
    .BASE_RES_Q (BASE_RES)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),    // [15:0] raw_count
    .in_tuser    (in_tuser),    // [0] action
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),   // [26:0] ambient_lux, [53:27] white_lux, [55:54] zero
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Total left shift of the base resolution for the current settings
  function automatic int unsigned res_shift();
    logic [2:0]  isel;
    int unsigned gsh;
    isel = (integ_now > INTEG_800) ? INTEG_800 : integ_now;
    case (gain_now)
      GAIN_X1:   gsh = 1;
      GAIN_X2:   gsh = 0;
      GAIN_X1_8: gsh = 4;
      GAIN_X1_4: gsh = 3;
      default:   gsh = 0;
    endcase
    return (INTEG_800 - isel) + gsh;
  endfunction

  function automatic logic [31:0] resolution();
    return 32'(BASE_RES) << res_shift();
  endfunction

  function automatic logic [LUX_W-1:0] scaled_lux(logic [15:0] cnt);
    logic [63:0] prod;
    prod = 64'(cnt) * 64'(resolution());
    return prod[LUX_W+15:16];
  endfunction

  // Smallest count whose scaled lux reaches the given level, or all ones
  function automatic logic [15:0] count_reaching(int unsigned lvl);
    longint unsigned c;
    c = (longint'(lvl) * 65536 + resolution() - 1) / resolution();
    return (c > 65535) ? 16'hFFFF : c[15:0];
  endfunction

  // Keep a Horner term inside the signed 80-bit range
  function automatic logic signed [127:0] clamp80(logic signed [127:0] v);
    if ((&v[127:79]) || !(|v[127:79])) return v;
    if (v[127]) return -(128'sd1 <<< 79);
    return (128'sd1 <<< 79) - 128'sd1;
  endfunction

  function automatic logic [OUT_W-1:0] quartic_fix(logic [LUX_W-1:0] l);
    logic signed [127:0] lv;
    logic signed [127:0] acc;
    lv  = signed'({103'd0, l});
    acc = clamp80(Q56_A * lv - Q56_B);
    acc = clamp80(acc * lv + Q56_C);
    acc = clamp80(acc * lv + Q56_D);
    acc = acc * lv;
    if (acc[127]) return '0;
    if (|acc[127:83]) return '1;
    return acc[82:56];
  endfunction

  function automatic logic [OUT_W-1:0] count_to_lux(logic [15:0] cnt);
    logic [LUX_W-1:0] l;
    l = scaled_lux(cnt);
    if (l > CORR_LIMIT) return quartic_fix(l);
    return {{(OUT_W-LUX_W){1'b0}}, l};
  endfunction

  // Offer one item, wait for acceptance, then record the expected lux pair.
  // Valid is left high on return; the next send or pause decides its level
  // in the same time step.
  task automatic send_count(logic chan, logic [15:0] cnt);
    int        gap;
    lux_pair_t want;
    gap = no_idle ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cnt;
    in_tuser  <= chan;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (scaled_lux(cnt) > CORR_LIMIT) corrected_items++;
    if (chan == CHAN_AMBIENT) held_ambient = count_to_lux(cnt);
    else held_white = count_to_lux(cnt);
    want.ambient = held_ambient;
    want.white   = held_white;
    expected_lux_q.push_back(want);
    items_sent++;
  endtask

  // Drop valid and hold off until every pending result has been taken
  task automatic drain_results();
    if (in_tvalid) in_tvalid <= 1'b0;
    while (expected_lux_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup then access; only while the block is drained
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
    drain_results();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    // Hold the bus idle before the next transfer
    @(posedge clk);
    if (addr == GAIN_ADDR) gain_now = data[1:0];
    else integ_now = data[2:0];
    reg_writes++;
  endtask

  task automatic set_scale(logic [1:0] g, logic [2:0] t);
    write_reg(GAIN_ADDR, 32'(g));
    write_reg(INTEG_ADDR, 32'(t));
  endtask

  // Reset settings: zero and full scale on both channels, then the counts
  // that land just below, on and just above the correction threshold.
  task automatic test_reset_settings();
    logic [15:0] at_limit;
    at_limit = count_reaching(CORR_LIMIT);
    send_count(CHAN_AMBIENT, 16'd0);
    send_count(CHAN_WHITE, 16'hFFFF);
    send_count(CHAN_AMBIENT, 16'hFFFF);
    send_count(CHAN_WHITE, 16'd0);
    send_count(CHAN_AMBIENT, at_limit - 16'd1);
    send_count(CHAN_AMBIENT, at_limit);
    send_count(CHAN_WHITE, count_reaching(CORR_LIMIT + 1));
    send_count(CHAN_WHITE, 16'd1);
    drain_results();
  endtask

  // Every gain at the shortest integration, the unused integration codes
  // that must behave like 800 ms, and the smallest overall scale.
  task automatic test_scale_extremes();
    for (int g = 0; g < 4; g++) begin
      set_scale(g[1:0], 3'd0);
      send_count(g[0], 16'hFFFF);
    end
    for (int t = 5; t < 8; t++) begin
      set_scale(GAIN_X1_8, t[2:0]);
      send_count(CHAN_WHITE, 16'hFFFF);
      send_count(CHAN_AMBIENT, count_reaching(CORR_LIMIT + 1));
    end
    set_scale(GAIN_X2, INTEG_800);
    send_count(CHAN_AMBIENT, 16'hFFFF);
    drain_results();
  endtask

  function automatic logic [15:0] pick_count();
    logic [15:0] edge_cnt;
    case ($urandom_range(0, 9))
      4: return 16'($urandom_range(0, 255));
      5: begin
        edge_cnt = count_reaching(CORR_LIMIT + 1);
        return (edge_cnt < 16'd4 || edge_cnt > 16'hFFF0) ? 16'($urandom)
                                                        : edge_cnt + 16'($urandom_range(0, 6)) - 16'd3;
      end
      6: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      7: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  // Random traffic in phases, each with its own settings and idling style
  task automatic test_random_traffic();
    logic [1:0] g;
    logic [2:0] t;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin g = GAIN_X1_8; t = 3'd0; end   // largest lux
        1: begin g = GAIN_X2;   t = 3'd7; end   // smallest lux, unused code
        default: begin
          g = 2'($urandom_range(0, 3));
          t = 3'($urandom_range(0, 7));
        end
      endcase
      set_scale(g, t);
      no_idle = (ph % 4 == 3);
      for (int n = 0; n < PHASE_LEN; n++) begin
        send_count(1'($urandom_range(0, 1)), pick_count());
        if (ph % 3 == 1 && n == PHASE_LEN / 2) drain_results();
      end
      no_idle = 1'b0;
    end
    drain_results();
  endtask

  // Result side: draw a stall per item, then take and check it
  initial begin : result_check
    int        stall;
    lux_pair_t want;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      results_checked++;
      if (expected_lux_q.size() == 0) begin
        $error("unexpected result: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = expected_lux_q.pop_front();
        if (out_tdata[26:0] !== want.ambient) begin
          $error("ambient_lux: expected %0d, got %0d", want.ambient, out_tdata[26:0]);
          fail_count++;
        end
        if (out_tdata[53:27] !== want.white) begin
          $error("white_lux: expected %0d, got %0d", want.white, out_tdata[53:27]);
          fail_count++;
        end
        if (out_tdata[55:54] !== 2'b00) begin
          $error("tdata pad: expected 0, got %0d", out_tdata[55:54]);
          fail_count++;
        end
      end
    end
  end

  initial begin : run_tests
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_scale_extremes();
    test_random_traffic();
    // Catch any stray result after the last expected one
    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_lux_q.size() != 0) begin
      $error("%0d results never arrived", expected_lux_q.size());
      fail_count++;
    end
    $display("Converted %0d counts on both channels, %0d through the quartic fix,",
             items_sent, corrected_items);
    $display("  %0d results checked; %0d register writes over every gain and integration code.",
             results_checked, reg_writes);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $error("run did not finish in time");
    $display("== FAIL ==");
    $finish;
  end

endmodule

FILE: files.f
rtl/alc_pkg.sv
rtl/alc_regs.sv
rtl/alc_mac.sv
rtl/ambient_light_lux_converter_top.sv
rtl/alc_chk.sv
verif/tb_top.sv
